// ----- rtl/cpq_pkg.sv -----
// Shared types and constants for the CE pushout packet queue.
// No dependencies; the other RTL files refer to it by scoped names, the testbench imports it.
package cpq_pkg;

	localparam int unsigned QueueDepth = 1024;
	localparam int unsigned PtrW = $clog2(QueueDepth);
	localparam int unsigned CntW = $clog2(QueueDepth + 1);
	localparam int unsigned HandleW = 16;
	localparam int unsigned LimitW = 11;
	localparam int unsigned KindW = 2;
	localparam int unsigned TosW = 8;
	localparam int unsigned StatusW = 3;

	typedef logic [PtrW-1:0] ptr_t;
	typedef logic [CntW-1:0] cnt_t;
	typedef logic [HandleW-1:0] handle_t;

	typedef enum logic [StatusW-1:0] {
		ST_ENQUEUED = 3'd0,
		ST_PUSHOUT  = 3'd1,
		ST_DROPPED  = 3'd2,
		ST_DEQUEUED = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		REQ_ENQ = 1'b0,
		REQ_DEQ = 1'b1
	} req_t;

	localparam logic [KindW-1:0] KindIpv4 = 2'd1;
	localparam logic [KindW-1:0] KindIpv6 = 2'd2;

	typedef enum logic [2:0] {
		OP_ENQ,
		OP_DEQ,
		OP_PUSH,
		OP_DROP,
		OP_EMPTY
	} op_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_RD,
		FSM_W2
	} fsm_t;

endpackage

// ----- rtl/cpq_req_if.sv -----
// Request channel: one enqueue or dequeue item.
// Depends on cpq_pkg for field widths.
interface cpq_req_if;
	logic                            valid;
	logic                            ready;
	logic                            req_type;
	logic [cpq_pkg::HandleW-1:0]     pkt_id;
	logic [cpq_pkg::KindW-1:0]       l3_kind;
	logic [cpq_pkg::TosW-1:0]        tos_byte;

	modport source (output valid, req_type, pkt_id, l3_kind, tos_byte, input ready);
	modport sink (input valid, req_type, pkt_id, l3_kind, tos_byte, output ready);
endinterface

// ----- rtl/cpq_rsp_if.sv -----
// Response channel: one result item per request.
// Depends on cpq_pkg for field widths.
interface cpq_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [cpq_pkg::StatusW-1:0]     status;
	logic [cpq_pkg::HandleW-1:0]     pkt_out_id;
	logic [cpq_pkg::LimitW-1:0]      queue_len;

	modport source (output valid, status, pkt_out_id, queue_len, input ready);
	modport sink (input valid, status, pkt_out_id, queue_len, output ready);
endinterface

// ----- rtl/cpq_cfg_if.sv -----
// Configuration write channel carrying the queue limit.
// Depends on cpq_pkg for the register width.
interface cpq_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [cpq_pkg::LimitW-1:0]    data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- rtl/ce_pushout_packet_queue_core.sv -----
// CE pushout packet queue: a descriptor FIFO held as a doubly linked list in
// slot memories, with a free list and a chain of CE-marked entries.
// Depends on cpq_pkg, the three channel interfaces and cpq_ram.
//
// Each request item yields one result item. The slot memories are read as the
// item is taken, then written back (drop and empty write nothing); a pushout
// adds a second write step (W2), since relinking the evicted slot at the tail
// needs a second write to the next/prev memories. The single read and write port
// of each slot memory forces that extra step. The result sits in an output
// register; a result still waiting holds the next item in its read step. The free
// list needs no clearing pass after reset: a watermark marks slots never
// handed out. The queue limit may be written whenever the block is idle.
module ce_pushout_packet_queue_core (
	input  logic       clk,
	input  logic       arst_n,
	cpq_cfg_if.sink    cfg,
	cpq_req_if.sink    req,
	cpq_rsp_if.source  rsp
);
	localparam cpq_pkg::cnt_t DepthCnt = cpq_pkg::cnt_t'(cpq_pkg::QueueDepth);

	cpq_pkg::fsm_t state_q, state_d;
	cpq_pkg::op_t op_q, op_d;

	cpq_pkg::ptr_t head_q, tail_q, fhead_q, newest_q, slot_q, raddr;
	cpq_pkg::cnt_t wm_q, occ_q, cecnt_q;
	logic [cpq_pkg::LimitW-1:0] limit_q, lim;
	cpq_pkg::handle_t id_q;
	logic ce_q, link_tail_q, ce_in, accept, go;

	logic ovalid_q;
	cpq_pkg::status_t ostatus_q;
	cpq_pkg::handle_t oid_q;
	logic [cpq_pkg::LimitW-1:0] olen_q;

	// memory ports
	logic h_we, c_we, n_we, p_we, pc_we, f_we;
	cpq_pkg::ptr_t h_wa, c_wa, n_wa, p_wa, pc_wa, f_wa;
	cpq_pkg::handle_t h_wd, h_rd;
	logic c_wd, c_rd;
	cpq_pkg::ptr_t n_wd, p_wd, pc_wd, f_wd, n_rd, p_rd, pc_rd, f_rd;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == cpq_pkg::FSM_IDLE);
	assign accept = req.valid && req.ready;
	assign go = !ovalid_q || rsp.ready;

	assign rsp.valid = ovalid_q;
	assign rsp.status = ostatus_q;
	assign rsp.pkt_out_id = oid_q;
	assign rsp.queue_len = olen_q;

	assign lim = (limit_q > DepthCnt) ? DepthCnt : limit_q;
	assign ce_in = (req.l3_kind == cpq_pkg::KindIpv4 || req.l3_kind == cpq_pkg::KindIpv6)
		&& (req.tos_byte[1:0] == 2'b11);

	function automatic logic link_tail_q_d();
		return (occ_q > cpq_pkg::cnt_t'(1)) && (slot_q != tail_q);
	endfunction

	// classify the arriving item and pick the slot to read
	always_comb begin
		op_d = cpq_pkg::OP_DROP;
		raddr = head_q;
		if (req.req_type == cpq_pkg::REQ_DEQ) begin
			op_d = (occ_q == '0) ? cpq_pkg::OP_EMPTY : cpq_pkg::OP_DEQ;
		end else if (lim == '0) begin
			op_d = cpq_pkg::OP_DROP;
		end else if (occ_q < lim) begin
			op_d = cpq_pkg::OP_ENQ;
			raddr = fhead_q;
		end else if (ce_in || cecnt_q == '0) begin
			op_d = cpq_pkg::OP_DROP;
		end else begin
			op_d = cpq_pkg::OP_PUSH;
			raddr = newest_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cpq_pkg::FSM_IDLE: begin
				if (accept) begin
					state_d = cpq_pkg::FSM_RD;
				end
			end
			cpq_pkg::FSM_RD: begin
				if (go) begin
					state_d = (op_q == cpq_pkg::OP_PUSH) ? cpq_pkg::FSM_W2 : cpq_pkg::FSM_IDLE;
				end
			end
			cpq_pkg::FSM_W2: begin
				if (go) begin
					state_d = cpq_pkg::FSM_IDLE;
				end
			end
			default: state_d = cpq_pkg::FSM_IDLE;
		endcase
	end

	// write-back to slot memories
	always_comb begin
		h_we = 1'b0; h_wa = slot_q; h_wd = id_q;
		c_we = 1'b0; c_wa = slot_q; c_wd = 1'b0;
		n_we = 1'b0; n_wa = tail_q; n_wd = slot_q;
		p_we = 1'b0; p_wa = slot_q; p_wd = tail_q;
		pc_we = 1'b0; pc_wa = slot_q; pc_wd = newest_q;
		f_we = 1'b0; f_wa = slot_q; f_wd = fhead_q;
		if (state_q == cpq_pkg::FSM_RD) begin
			unique case (op_q)
				cpq_pkg::OP_ENQ: begin
					h_we = go;
					c_we = go;
					c_wd = ce_q;
					n_we = go && (occ_q != '0);
					p_we = go && (occ_q != '0);
					pc_we = go && ce_q;
				end
				cpq_pkg::OP_DEQ: begin
					f_we = go;
				end
				cpq_pkg::OP_PUSH: begin
					h_we = go;
					c_we = go;
					// splice a middle victim out
					if (go && link_tail_q_d() && slot_q != head_q) begin
						n_we = 1'b1; n_wa = p_rd; n_wd = n_rd;
						p_we = 1'b1; p_wa = n_rd; p_wd = p_rd;
					end
				end
				default: ;
			endcase
		end else if (state_q == cpq_pkg::FSM_W2) begin
			n_we = go && link_tail_q;
			p_we = go && link_tail_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpq_pkg::FSM_IDLE;
			limit_q <= cpq_pkg::LimitW'(cpq_pkg::QueueDepth);
			head_q <= '0;
			tail_q <= '0;
			fhead_q <= '0;
			newest_q <= '0;
			wm_q <= '0;
			occ_q <= '0;
			cecnt_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				limit_q <= cfg.data;
			end
			if (go && ((state_q == cpq_pkg::FSM_RD && op_q != cpq_pkg::OP_PUSH)
				|| state_q == cpq_pkg::FSM_W2)) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			if (state_q == cpq_pkg::FSM_RD) begin
				unique case (op_q)
					cpq_pkg::OP_ENQ: begin
						if (go) begin
							if ({1'b0, fhead_q} == wm_q) begin
								fhead_q <= fhead_q + 1'b1;
								wm_q <= wm_q + 1'b1;
							end else begin
								fhead_q <= f_rd;
							end
							if (occ_q == '0) begin
								head_q <= fhead_q;
							end
							tail_q <= fhead_q;
							if (ce_q) begin
								newest_q <= fhead_q;
								cecnt_q <= cecnt_q + 1'b1;
							end
							occ_q <= occ_q + 1'b1;
						end
					end
					cpq_pkg::OP_DEQ: begin
						if (go) begin
							if (c_rd && cecnt_q != '0) begin
								cecnt_q <= cecnt_q - 1'b1;
							end
							if (occ_q == cpq_pkg::cnt_t'(1)) begin
								head_q <= '0;
								tail_q <= '0;
							end else begin
								head_q <= n_rd;
							end
							occ_q <= occ_q - 1'b1;
							fhead_q <= slot_q;
						end
					end
					cpq_pkg::OP_PUSH: begin
						if (go) begin
							cecnt_q <= cecnt_q - 1'b1;
							newest_q <= pc_rd;
							if (occ_q == cpq_pkg::cnt_t'(1)) begin
								head_q <= slot_q;
								tail_q <= slot_q;
							end else if (slot_q == head_q) begin
								head_q <= n_rd;
							end
						end
					end
					default: ;
				endcase
			end else if (state_q == cpq_pkg::FSM_W2 && go) begin
				if (link_tail_q) begin
					tail_q <= slot_q;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_d;
			slot_q <= raddr;
			id_q <= req.pkt_id;
			ce_q <= ce_in;
		end
		if (state_q == cpq_pkg::FSM_RD) begin
			link_tail_q <= link_tail_q_d();
			if (go && op_q != cpq_pkg::OP_PUSH) begin
				unique case (op_q)
					cpq_pkg::OP_ENQ: begin
						ostatus_q <= cpq_pkg::ST_ENQUEUED;
						oid_q <= '0;
						olen_q <= occ_q + 1'b1;
					end
					cpq_pkg::OP_DEQ: begin
						ostatus_q <= cpq_pkg::ST_DEQUEUED;
						oid_q <= h_rd;
						olen_q <= occ_q - 1'b1;
					end
					cpq_pkg::OP_EMPTY: begin
						ostatus_q <= cpq_pkg::ST_EMPTY;
						oid_q <= '0;
						olen_q <= occ_q;
					end
					default: begin
						ostatus_q <= cpq_pkg::ST_DROPPED;
						oid_q <= id_q;
						olen_q <= occ_q;
					end
				endcase
			end
			if (go && op_q == cpq_pkg::OP_PUSH) begin
				// hold the victim handle until the tail relink is done
				oid_q <= h_rd;
			end
		end else if (state_q == cpq_pkg::FSM_W2 && go) begin
			ostatus_q <= cpq_pkg::ST_PUSHOUT;
			olen_q <= occ_q;
		end
	end

	cpq_ram #(.Width(cpq_pkg::HandleW), .Depth(cpq_pkg::QueueDepth)) u_handle (
		.clk, .we(h_we), .waddr(h_wa), .wdata(h_wd), .re(accept), .raddr, .rdata(h_rd));
	cpq_ram #(.Width(1), .Depth(cpq_pkg::QueueDepth)) u_is_ce (
		.clk, .we(c_we), .waddr(c_wa), .wdata(c_wd), .re(accept), .raddr, .rdata(c_rd));
	cpq_ram #(.Width(cpq_pkg::PtrW), .Depth(cpq_pkg::QueueDepth)) u_next (
		.clk, .we(n_we), .waddr(n_wa), .wdata(n_wd), .re(accept), .raddr, .rdata(n_rd));
	cpq_ram #(.Width(cpq_pkg::PtrW), .Depth(cpq_pkg::QueueDepth)) u_prev (
		.clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .re(accept), .raddr, .rdata(p_rd));
	cpq_ram #(.Width(cpq_pkg::PtrW), .Depth(cpq_pkg::QueueDepth)) u_prev_ce (
		.clk, .we(pc_we), .waddr(pc_wa), .wdata(pc_wd), .re(accept), .raddr,
		.rdata(pc_rd));
	cpq_ram #(.Width(cpq_pkg::PtrW), .Depth(cpq_pkg::QueueDepth)) u_free_link (
		.clk, .we(f_we), .waddr(f_wa), .wdata(f_wd), .re(accept), .raddr, .rdata(f_rd));

endmodule

// ----- rtl/cpq_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module cpq_ram #(
	parameter int unsigned Width = 16,
	parameter int unsigned Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- tb/sv/cpq_tb_if.sv -----
`timescale 1ns / 1ps
// Testbench-side note: the channel interfaces themselves live with the RTL.
// This file holds the small helper package of item structs; depends on cpq_pkg.
package cpq_tb_pkg;
	typedef struct packed {
		cpq_pkg::req_t                 req_type;
		logic [cpq_pkg::HandleW-1:0]   pkt_id;
		logic [cpq_pkg::KindW-1:0]     l3_kind;
		logic [cpq_pkg::TosW-1:0]      tos_byte;
	} pkt_req_t;

	typedef struct packed {
		cpq_pkg::status_t              status;
		logic [cpq_pkg::HandleW-1:0]   pkt_out_id;
		logic [cpq_pkg::LimitW-1:0]    queue_len;
	} pkt_rsp_t;
endpackage

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for ce_pushout_packet_queue_core: drives enqueue/dequeue items,
// predicts each result with a software queue model and checks it field by field.
// Depends on cpq_pkg, cpq_tb_pkg and the three channel interfaces.
module testbench;
	import cpq_pkg::*;
	import cpq_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit failed = 1'b0;

	cpq_cfg_if cfg ();
	cpq_req_if req ();
	cpq_rsp_if rsp ();

	ce_pushout_packet_queue_core u_top (
		.clk(clk), .arst_n(arst_n), .cfg(cfg.sink), .req(req.sink), .rsp(rsp.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// queue model: handles and CE marks in arrival order
	logic [HandleW-1:0] q_handle[$];
	bit q_ce[$];
	int unsigned cur_limit = 1024;
	pkt_rsp_t expected_rsp[$];
	bit stall_rx = 1'b0;

	function automatic pkt_rsp_t predict_result(pkt_req_t it);
		pkt_rsp_t r;
		int unsigned lim;
		bit ce;
		int idx;
		lim = (cur_limit > QueueDepth) ? QueueDepth : cur_limit;
		r.pkt_out_id = '0;
		if (it.req_type == REQ_DEQ) begin
			if (q_handle.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.status = ST_DEQUEUED;
				r.pkt_out_id = q_handle.pop_front();
				void'(q_ce.pop_front());
			end
		end else begin
			ce = (it.l3_kind == KindIpv4 || it.l3_kind == KindIpv6) && it.tos_byte[1:0] == 2'b11;
			idx = -1;
			for (int i = q_ce.size() - 1; i >= 0; i--)
				if (q_ce[i] && idx < 0) idx = i;
			if (lim == 0) begin
				r.status = ST_DROPPED;
				r.pkt_out_id = it.pkt_id;
			end else if (q_handle.size() < lim) begin
				r.status = ST_ENQUEUED;
				q_handle.push_back(it.pkt_id);
				q_ce.push_back(ce);
			end else if (ce || idx < 0) begin
				r.status = ST_DROPPED;
				r.pkt_out_id = it.pkt_id;
			end else begin
				// evict newest CE entry, append arrival as non-CE
				r.status = ST_PUSHOUT;
				r.pkt_out_id = q_handle[idx];
				q_handle.delete(idx);
				q_ce.delete(idx);
				q_handle.push_back(it.pkt_id);
				q_ce.push_back(1'b0);
			end
		end
		r.queue_len = LimitW'(q_handle.size());
		return r;
	endfunction

	task automatic send_item(pkt_req_t it);
		req.valid <= 1'b1;
		req.req_type <= it.req_type;
		req.pkt_id <= it.pkt_id;
		req.l3_kind <= it.l3_kind;
		req.tos_byte <= it.tos_byte;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		expected_rsp.push_back(predict_result(it));
	endtask

	task automatic pause(int n);
		req.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(int unsigned v);
		wait_drained();
		cfg.valid <= 1'b1;
		cfg.data <= LimitW'(v);
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		cur_limit = v;
	endtask

	function automatic pkt_req_t make_enq(logic [HandleW-1:0] id, bit ce);
		pkt_req_t it;
		it.req_type = REQ_ENQ;
		it.pkt_id = id;
		it.l3_kind = ce ? 2'(KindIpv4 + $urandom_range(0, 1)) : 2'($urandom_range(0, 3));
		it.tos_byte = 8'($urandom_range(0, 255));
		if (ce) it.tos_byte[1:0] = 2'b11;
		else if (it.l3_kind == KindIpv4 || it.l3_kind == KindIpv6) it.tos_byte[1] = 1'b0;
		return it;
	endfunction

	function automatic pkt_req_t make_deq();
		pkt_req_t it;
		it = make_enq(16'($urandom_range(0, 65535)), 1'b0);
		it.req_type = REQ_DEQ;
		return it;
	endfunction

	// send one item per call with bursty gaps
	int burst_left = 0;
	task automatic send_bursty(pkt_req_t it);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 6));
		end
		burst_left--;
		send_item(it);
	endtask

	task automatic test_directed();
		pkt_req_t it;
		send_item(make_deq());
		write_limit(3);
		send_item(make_enq(16'h0000, 1'b1));
		it = make_enq(16'hFFFF, 1'b0);
		it.l3_kind = 2'd3;
		it.tos_byte = 8'hFF;
		send_item(it);
		send_item(make_enq(16'h1234, 1'b1));
		send_item(make_enq(16'h5555, 1'b1));
		send_item(make_enq(16'hAAAA, 1'b0));
		send_item(make_enq(16'h0F0F, 1'b0));
		send_item(make_enq(16'h7777, 1'b0));
		repeat (4) send_item(make_deq());
		write_limit(0);
		send_item(make_enq(16'h8001, 1'b0));
		send_item(make_deq());
		write_limit(2047);
		it = make_enq(16'h4242, 1'b0);
		it.l3_kind = KindIpv6;
		it.tos_byte = 8'h02;
		send_item(it);
		send_item(make_enq(16'h4343, 1'b1));
		write_limit(1);
		send_item(make_enq(16'h9999, 1'b0));
		send_item(make_enq(16'h9998, 1'b1));
		repeat (2) send_item(make_deq());
	endtask

	task automatic test_random_phase(int unsigned lim, int n);
		write_limit(lim);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 40 + (q_handle.size() > lim ? 20 : 0))
				send_bursty(make_deq());
			else
				send_bursty(make_enq(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1))));
		end
		wait_drained();
	endtask

	// result checker
	always @(posedge clk) begin
		pkt_rsp_t e;
		if (rsp.valid && rsp.ready) begin
			if (expected_rsp.size() == 0) begin
				$error("unexpected result status=%0d", rsp.status);
				failed = 1'b1;
			end else begin
				e = expected_rsp.pop_front();
				if (rsp.status !== e.status) begin
					$error("status: expected %0d actual %0d", e.status, rsp.status);
					failed = 1'b1;
				end
				if (rsp.pkt_out_id !== e.pkt_out_id) begin
					$error("pkt_out_id: expected %0h actual %0h", e.pkt_out_id, rsp.pkt_out_id);
					failed = 1'b1;
				end
				if (rsp.queue_len !== e.queue_len) begin
					$error("queue_len: expected %0d actual %0d", e.queue_len, rsp.queue_len);
					failed = 1'b1;
				end
			end
		end
	end

	// receiver stall pattern: runs of ready and stalls, with quiet stretches
	always @(posedge clk) begin
		int unsigned k;
		k = $urandom_range(0, 99);
		if (!arst_n) rsp.ready <= 1'b0;
		else rsp.ready <= (k < 70) || stall_rx == 1'b0 && k < 95;
	end
	always @(posedge clk) if ($urandom_range(0, 63) == 0) stall_rx <= ~stall_rx;

	initial begin
		req.valid = 1'b0;
		req.req_type = REQ_ENQ;
		req.pkt_id = '0;
		req.l3_kind = '0;
		req.tos_byte = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phase(8, 150);
		test_random_phase(1, 60);
		test_random_phase(40, 150);
		test_random_phase(1024, 80);
		test_random_phase(0, 20);
		test_random_phase(5, 60);
		wait_drained();
		repeat (20) @(posedge clk);
		if (!failed && expected_rsp.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
